FILE: hdl/sha256_pkg.sv
package sha256_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_OFFSET  = 56;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  typedef logic [31:0] word_t;

  localparam word_t INITIAL_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

FILE: hdl/sha256_if.sv
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: hdl/sha256_byte_stream_hasher_core.sv
// Channel  Dir  Payload                                   Handshake
// in       in   data_byte[7:0] byte_present end_of_message  valid/ready
// out      out  digest_word[31:0] word_index[2:0] last_word valid/ready
//
// A byte transfer is accepted whenever the block is filling; an item with neither
// flag is accepted and stores nothing. A full block runs a load pass (16 word
// reads through the registered block memory, plus a step for the last word to
// arrive), 64 rounds and one fold step, with input held throughout.
// An end item fills padding one byte a cycle up to the block end, compresses
// once or twice, then emits eight words, one per output transfer.
// Reset is synchronous; the block memory has no reset and no clearing pass.
// A stalled output holds the current word; input waits until the digest leaves.
module sha256_byte_stream_hasher_core
  import sha256_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  sha256_in_if.sink       in_ch,
  sha256_out_if.source    out_ch
);

  // block memory: 16 big-endian words, one byte lane written per cycle
  logic [31:0] buf_mem [BLOCK_BYTES / 4];
  logic [7:0]  buf_wdata;
  logic [5:0]  buf_waddr;
  logic        buf_we;
  logic [3:0]  buf_raddr;
  word_t       buf_rdata;

  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[buf_waddr[5:2]][{~buf_waddr[1:0], 3'b000} +: 8] <= buf_wdata;
    buf_rdata <= buf_mem[buf_raddr];
  end

  state_t      state, state_next;
  word_t       chain [8];
  word_t       v [8];
  word_t       w [16];
  logic [5:0]  fill;
  logic [60:0] count;
  logic [6:0]  round;
  logic        padding;   // end seen, writing padding bytes
  logic        final_blk; // block being filled or compressed carries the length
  logic        pad_first; // 0x80 still owed after an end item that carried a byte
  logic [2:0]  emit_idx;

  logic in_fire, out_fire;
  assign in_ch.ready = (state == ST_COLLECT) && !padding;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  logic [63:0] bits;
  logic [63:0] len_shift;
  assign bits      = {count, 3'd0};
  // length byte for positions 56..63, most significant first
  assign len_shift = bits >> {~fill[2:0], 3'b000};

  // padding byte at the current fill position
  logic [7:0] pad_byte;
  always_comb begin
    if (pad_first) pad_byte = PAD_BYTE;
    else if (final_blk && fill >= 6'(LEN_OFFSET)) pad_byte = len_shift[7:0];
    else pad_byte = 8'd0;
  end

  always_comb begin
    buf_we    = 1'b0;
    buf_waddr = fill;
    buf_wdata = in_ch.data_byte;
    if (in_fire) begin
      if (in_ch.byte_present) begin
        buf_we = 1'b1;
      end else if (in_ch.end_of_message) begin
        buf_we = 1'b1; buf_wdata = PAD_BYTE;
      end
    end else if (state == ST_COLLECT && padding) begin
      buf_we = 1'b1; buf_wdata = pad_byte;
    end
  end

  assign buf_raddr = (state == ST_LOAD) ? round[3:0] : 4'd0;

  // round datapath
  logic [5:0] r6;
  logic [3:0] slot;
  word_t wt, s0, s1, t1, t2, w15, w2;
  assign r6   = round[5:0];
  assign slot = r6[3:0];
  assign w15  = w[slot + 4'd1];
  assign w2   = w[slot + 4'd14];
  assign s0   = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
  assign s1   = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
  assign wt   = (r6 >= 6'd16) ? s1 + w[slot + 4'd9] + s0 + w[slot] : w[slot];
  assign t1   = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
                ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r6] + wt;
  assign t2   = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
                ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        if (in_fire && (in_ch.byte_present || in_ch.end_of_message) && fill == 6'd63)
          state_next = ST_LOAD;
        else if (padding && fill == 6'd63) state_next = ST_LOAD;
      end
      ST_LOAD:  if (round == 7'd16) state_next = ST_ROUND;
      ST_ROUND: if (round == 7'd63) state_next = ST_FOLD;
      ST_FOLD:  state_next = final_blk ? ST_EMIT : ST_COLLECT;
      ST_EMIT:  if (out_fire && emit_idx == 3'd7) state_next = ST_COLLECT;
      default:  state_next = ST_COLLECT;
    endcase
  end

  // outputs
  always_comb begin
    out_ch.valid       = (state == ST_EMIT);
    out_ch.digest_word = chain[emit_idx];
    out_ch.word_index  = emit_idx;
    out_ch.last_word   = (emit_idx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COLLECT;
      fill      <= '0;
      count     <= '0;
      round     <= '0;
      padding   <= 1'b0;
      final_blk <= 1'b0;
      pad_first <= 1'b0;
      emit_idx  <= '0;
      chain     <= INITIAL_H;
    end else begin
      state <= state_next;
      unique case (state)
        ST_COLLECT: begin
          if (in_fire) begin
            if (in_ch.byte_present) begin
              fill  <= fill + 6'd1;
              count <= count + 61'd1;
              // end with a byte: the pad byte follows in padding mode
              if (in_ch.end_of_message) begin
                padding   <= 1'b1;
                pad_first <= 1'b1;
              end
            end else if (in_ch.end_of_message) begin
              fill      <= fill + 6'd1;
              padding   <= 1'b1;
              final_blk <= fill < 6'(LEN_OFFSET);
            end
          end else if (padding) begin
            fill <= fill + 6'd1;
            // 0x80 lands here; the length fits only if it sits before byte 56
            if (pad_first) begin
              pad_first <= 1'b0;
              final_blk <= fill < 6'(LEN_OFFSET);
            end
          end
          round <= '0;
        end
        ST_LOAD: begin
          // memory word r-1 arrives this cycle
          if (round != 7'd0) w[round[3:0] - 4'd1] <= buf_rdata;
          round <= (round == 7'd16) ? 7'd0 : round + 7'd1;
          v <= chain;
        end
        ST_ROUND: begin
          w[slot] <= wt;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          round <= round + 7'd1;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
          round <= '0;
          fill  <= '0;
          // padding overflow: the length goes into the next block
          if (padding) final_blk <= 1'b1;
          if (final_blk) padding <= 1'b0;
        end
        ST_EMIT: begin
          if (out_fire) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              chain     <= INITIAL_H;
              count     <= '0;
              final_blk <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_ch.valid |-> !in_ch.ready)
    else $error("input taken while digest pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |=> (state == ST_ROUND || state == ST_FOLD))
    else $error("round sequence broken");
  assert property (@(posedge clk) disable iff (rst)
    (out_fire && emit_idx == 3'd7) |=> (state == ST_COLLECT && emit_idx == 3'd0))
    else $error("digest emit did not close");

endmodule
